// ===== rtl/kpi_pkg.sv =====
// Shared types and constants for the keyframe pose interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none
package kpi_pkg;
	localparam int MAX_KEYS = 256;
	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = AW + 1;

	localparam logic REG_START_TIME = 1'b0;
	localparam logic REG_RECORD_INTERVAL = 1'b1;
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [31:0] time_value;
		logic signed [31:0] pos_x_in;
		logic signed [31:0] pos_y_in;
		logic signed [31:0] pos_z_in;
		logic signed [15:0] pitch_in;
		logic signed [15:0] bank_in;
		logic signed [15:0] heading_in;
		logic signed [15:0] segment_in;
	} in_item_t;

	typedef struct packed {
		logic               done_res;
		logic signed [31:0] pos_x_out;
		logic signed [31:0] pos_y_out;
		logic signed [31:0] pos_z_out;
		logic signed [15:0] pitch_out;
		logic signed [15:0] bank_out;
		logic signed [15:0] heading_out;
		logic signed [15:0] segment_out;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [15:0] p;
		logic signed [15:0] b;
		logic signed [15:0] h;
		logic signed [15:0] seg;
	} key_t;

	// Handshake between the sequencer and the serial divider.
	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/kpi_div.sv =====
// Radix-2 restoring divider for the interpolation scale, one quotient bit a cycle.
// Depends on kpi_pkg; computes sat32((extra << 16) / gap), truncated toward zero.
`default_nettype none
module kpi_div
	import kpi_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] extra,
	input  wire logic signed [31:0] gap,
	output logic                    busy,
	output logic signed [31:0]      quot
);
	logic [47:0] num_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [47:0] abs_num;
	logic [33:0] trial;
	logic [32:0] shifted;

	assign abs_num = extra[31] ? (48'd0 - {extra, 16'd0}) : {extra, 16'd0};
	assign shifted = {rem_q[31:0], num_q[47]};
	assign trial = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd48;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= abs_num;
			den_q <= gap[31] ? (32'd0 - gap) : gap;
			neg_q <= extra[31] ^ gap[31];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	// Saturate the signed result to 32 bits.
	always_comb begin
		if (neg_q) begin
			if (quo_q > 48'h0000_8000_0000) begin
				quot = 32'sh8000_0000;
			end else begin
				quot = 32'(48'd0 - quo_q);
			end
		end else if (quo_q > 48'h0000_7FFF_FFFF) begin
			quot = 32'sh7FFF_FFFF;
		end else begin
			quot = quo_q[31:0];
		end
	end

	assign busy = busy_q;
endmodule
`default_nettype wire

// ===== rtl/kpi_mul.sv =====
// Shared signed 32x32 multiplier with a registered floor(a*s >> 16) result.
// Depends on kpi_pkg.
`default_nettype none
module kpi_mul
	import kpi_pkg::*;
(
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] s,
	output logic signed [31:0]      prod_q
);
	logic signed [63:0] p;
	assign p = a * s;
	always_ff @(posedge clk) begin
		prod_q <= p[47:16];
	end
endmodule
`default_nettype wire

// ===== rtl/keyframe_pose_interpolator.sv =====
// Keyframe pose interpolator: records timed poses and answers interpolated pose queries.
// Records pass through the REC state back to idle. A query walks N keys (1..256), each in an
// address state and then a registered read, then fetches the pair, runs the serial divider,
// does six shared multiplies, presents the result and returns to idle. A done result skips the
// fetch, divider and multiplies. One transaction is in flight at a time; output stalls delay the next.
// arst_n clears the key count, last record time and sequencer; the store is read below the count.
`default_nettype none
module keyframe_pose_interpolator
	import kpi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_REC = 4'd1;
	localparam logic [3:0] ST_WALK = 4'd2;
	localparam logic [3:0] ST_RD0 = 4'd3;
	localparam logic [3:0] ST_RD1 = 4'd4;
	localparam logic [3:0] ST_DIVS = 4'd5;
	localparam logic [3:0] ST_DIVW = 4'd6;
	localparam logic [3:0] ST_MUL = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;

	logic [3:0]         state_q;
	logic signed [31:0] start_time_q;
	logic [30:0]        interval_q;
	logic [CW-1:0]      key_count_q;
	logic signed [31:0] last_rec_q;
	in_item_t           item_q;
	logic signed [31:0] rel_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      rd_addr;
	key_t               rd_data_q;
	key_t               k0_q;
	key_t               k1_q;
	logic [2:0]         mstep_q;
	logic signed [31:0] scale_q;
	out_item_t          res_q;
	logic               out_valid_q;
	key_t               mem [MAX_KEYS];
	logic signed [31:0] rel_in;
	logic signed [31:0] rec_diff;
	div_ctl_t           dctl;
	logic signed [31:0] quot;
	logic signed [31:0] mul_a;
	logic signed [31:0] prod_q;
	logic [CW-1:0]      rec_idx;
	logic               walk_on;
	logic               at_end;

	assign rel_in = in_data.time_value - start_time_q;
	assign rec_diff = item_q.time_value - last_rec_q;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign rd_addr = idx_q[AW-1:0];
	// The earlier bracketing key sits one below where the walk stopped, unless at zero.
	assign rec_idx = (idx_q == '0) ? '0 : idx_q - 1'b1;
	// The walk moves on while a later key exists and the query lies beyond this one.
	assign walk_on = (idx_q + 1'b1 < key_count_q) && (rel_q > rd_data_q.t);
	// Playback is over when too few keys remain after the earlier bracketing key.
	assign at_end = (key_count_q < CW'(3)) || (rec_idx >= key_count_q - CW'(2));
	assign dctl.start = (state_q == ST_DIVS);

	// Keyframe memory: one write port for records, one registered read port for the walk and pair fetch.
	always_ff @(posedge clk) begin
		if (state_q == ST_REC && rec_diff >= $signed({1'b0, interval_q})
		    && key_count_q < CW'(MAX_KEYS)) begin
			mem[key_count_q[AW-1:0]] <= '{t: rel_q, x: item_q.pos_x_in, y: item_q.pos_y_in,
				z: item_q.pos_z_in, p: item_q.pitch_in, b: item_q.bank_in,
				h: item_q.heading_in, seg: item_q.segment_in};
		end
		rd_data_q <= mem[rd_addr];
	end

	kpi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dctl.start),
		.extra(rel_q - k0_q.t), .gap(k1_q.t - k0_q.t),
		.busy(dctl.busy), .quot(quot)
	);

	// Multiplier operand: the k1 - k0 delta of each pose field in turn.
	always_comb begin
		case (mstep_q)
			3'd0: mul_a = k1_q.x - k0_q.x;
			3'd1: mul_a = k1_q.y - k0_q.y;
			3'd2: mul_a = k1_q.z - k0_q.z;
			3'd3: mul_a = 32'(signed'(16'(k1_q.p - k0_q.p)));
			3'd4: mul_a = 32'(signed'(16'(k1_q.b - k0_q.b)));
			3'd5: mul_a = 32'(signed'(16'(k1_q.h - k0_q.h)));
			default: mul_a = '0;
		endcase
	end

	kpi_mul u_mul (.clk(clk), .a(mul_a), .s(scale_q), .prod_q(prod_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_time_q <= '0;
			interval_q <= 31'd65536;
			key_count_q <= '0;
			last_rec_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			mstep_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_START_TIME) begin
					start_time_q <= cfg_data;
				end else begin
					interval_q <= cfg_data[30:0];
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						idx_q <= '0;
						state_q <= (in_data.op == OP_RECORD) ? ST_REC : ST_WALK;
					end
				end
				ST_REC: begin
					if (rec_diff >= $signed({1'b0, interval_q})) begin
						last_rec_q <= item_q.time_value;
						if (key_count_q < CW'(MAX_KEYS)) begin
							key_count_q <= key_count_q + 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					// rd_data_q holds entry idx_q in the cycle after the address is set,
					// so this state alternates with a read cycle.
					state_q <= ST_RD0;
				end
				ST_RD0: begin
					if (walk_on) begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_WALK;
					end else if (at_end) begin
						state_q <= ST_OUT;
					end else begin
						idx_q <= rec_idx;
						state_q <= ST_RD1;
						mstep_q <= '0;
					end
				end
				ST_RD1: begin
					// mstep counts the two reads of k0 and k1.
					if (mstep_q == 3'd3) begin
						k1_q <= rd_data_q;
						mstep_q <= '0;
						state_q <= ST_DIVS;
					end else begin
						mstep_q <= mstep_q + 3'd1;
						if (mstep_q == 3'd1) begin
							k0_q <= rd_data_q;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (!dctl.busy) begin
						mstep_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd6) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: operands, scale and the result being assembled.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			item_q <= in_data;
			rel_q <= rel_in;
		end
		// Playback over: the result carries only the done flag.
		if (state_q == ST_RD0 && !walk_on && at_end) begin
			res_q <= '{done_res: 1'b1, default: '0};
		end
		if (state_q == ST_DIVW && !dctl.busy) begin
			scale_q <= (k1_q.t == k0_q.t) ? 32'sd0 : quot;
		end
		if (state_q == ST_DIVS) begin
			res_q <= '{done_res: 1'b0, pos_x_out: k0_q.x, pos_y_out: k0_q.y,
				pos_z_out: k0_q.z, pitch_out: k0_q.p, bank_out: k0_q.b,
				heading_out: k0_q.h, segment_out: k0_q.seg};
		end
		// A query at relative time zero keeps the earlier key without interpolation.
		if (state_q == ST_MUL && mstep_q != 3'd0 && rel_q != 32'sd0) begin
			case (mstep_q)
				3'd1: res_q.pos_x_out <= k0_q.x + prod_q;
				3'd2: res_q.pos_y_out <= k0_q.y + prod_q;
				3'd3: res_q.pos_z_out <= k0_q.z + prod_q;
				3'd4: res_q.pitch_out <= k0_q.p + prod_q[15:0];
				3'd5: res_q.bank_out <= k0_q.b + prod_q[15:0];
				3'd6: res_q.heading_out <= k0_q.h + prod_q[15:0];
				default: res_q.segment_out <= k0_q.seg;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = res_q;

	// The store never holds more keys than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CW'(MAX_KEYS)) else $error("key count overflow");
	// No new transaction is taken while a result waits.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready) else $error("accepted while result pending");
	// The key count moves by at most one per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q != $past(key_count_q) |-> key_count_q == $past(key_count_q) + 1'b1)
		else $error("key count jumped");
endmodule
`default_nettype wire
